// ===== hw/rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Byte classes, constants and the per-byte result burst shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [15:0] Replacement  = 16'h003F;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;

  typedef enum logic [2:0] {
    CLS_CONT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_cls_t;

  // All code units that one input byte causes, in output order.
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                count;     // 0 to 4 valid units
    logic                      str_last;  // the byte closed its string
  } burst_t;

  // Class of a byte from its five upper bits.
  function automatic byte_cls_t byte_class(input logic [4:0] top);
    byte_cls_t cls;
    priority if (top[4] == 1'b0) begin
      cls = CLS_ASCII;
    end else if (top[4:3] == 2'b10) begin
      cls = CLS_CONT;
    end else if (top[4:2] == 3'b110) begin
      cls = CLS_LEAD2;
    end else if (top[4:1] == 4'b1110) begin
      cls = CLS_LEAD3;
    end else if (top == 5'b11110) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8u16_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the pending sequence and turns each accepted byte into a result burst.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output u8u16_pkg::burst_t      burst,
  output logic                   push
);

  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  collected_r, collected_nxt;
  logic [20:0] partial_r, partial_nxt;

  u8u16_pkg::byte_cls_t cls;
  logic [20:0] cont_code;
  logic [20:0] supp_off;
  logic [1:0]  cont_count;
  logic [2:0]  num_repl;
  logic        fresh_en;
  logic        tail_vld;
  logic [15:0] tail_unit;
  logic        pair_en;
  logic [15:0] high_unit;
  logic [15:0] low_unit;

  always_comb begin
    cls           = u8u16_pkg::byte_class(in_byte[7:3]);
    cont_code     = {partial_r[14:0], in_byte[5:0]};
    cont_count    = collected_r + 2'd1;
    supp_off      = cont_code - u8u16_pkg::SuppBase;
    // Code points past 0x10FFFF carry an eleventh bit into the high unit.
    high_unit     = u8u16_pkg::HighSurrBase + {5'd0, supp_off[20:10]};
    low_unit      = u8u16_pkg::LowSurrBase + {6'd0, supp_off[9:0]};
    needed_nxt    = needed_r;
    collected_nxt = collected_r;
    partial_nxt   = partial_r;
    num_repl      = 3'd0;
    fresh_en      = 1'b0;
    tail_vld      = 1'b0;
    tail_unit     = u8u16_pkg::Replacement;
    pair_en       = 1'b0;

    if (needed_r != 2'd0) begin
      if (cls == u8u16_pkg::CLS_CONT) begin
        if (cont_count >= needed_r) begin
          needed_nxt    = 2'd0;
          collected_nxt = 2'd0;
          partial_nxt   = '0;
          if (cont_code < u8u16_pkg::SuppBase) begin
            tail_vld  = 1'b1;
            tail_unit = cont_code[15:0];
          end else begin
            pair_en = 1'b1;
          end
        end else if (in_last) begin
          // Truncated at the string end: one '?' for the lead and each continuation.
          num_repl      = 3'd1 + {1'b0, cont_count};
          needed_nxt    = 2'd0;
          collected_nxt = 2'd0;
          partial_nxt   = '0;
        end else begin
          collected_nxt = cont_count;
          partial_nxt   = cont_code;
        end
      end else begin
        // Broken sequence; the breaking byte is then decoded as a fresh byte.
        num_repl      = 3'd1 + {1'b0, collected_r};
        needed_nxt    = 2'd0;
        collected_nxt = 2'd0;
        partial_nxt   = '0;
        fresh_en      = 1'b1;
      end
    end else begin
      fresh_en = 1'b1;
    end

    if (fresh_en) begin
      unique case (cls)
        u8u16_pkg::CLS_ASCII: begin
          tail_vld  = 1'b1;
          tail_unit = {8'd0, in_byte};
        end
        u8u16_pkg::CLS_LEAD2, u8u16_pkg::CLS_LEAD3, u8u16_pkg::CLS_LEAD4: begin
          if (in_last) begin
            num_repl = num_repl + 3'd1;
          end else begin
            unique case (cls)
              u8u16_pkg::CLS_LEAD2: begin
                needed_nxt  = 2'd1;
                partial_nxt = {16'd0, in_byte[4:0]};
              end
              u8u16_pkg::CLS_LEAD3: begin
                needed_nxt  = 2'd2;
                partial_nxt = {17'd0, in_byte[3:0]};
              end
              default: begin
                needed_nxt  = 2'd3;
                partial_nxt = {18'd0, in_byte[2:0]};
              end
            endcase
            collected_nxt = 2'd0;
          end
        end
        default: begin
          tail_vld  = 1'b1;
          tail_unit = u8u16_pkg::Replacement;
        end
      endcase
    end
  end

  always_comb begin
    burst.str_last = in_last;
    if (pair_en) begin
      burst.units    = '0;
      burst.units[0] = high_unit;
      burst.units[1] = low_unit;
      burst.count    = 3'd2;
    end else begin
      for (int i = 0; i < u8u16_pkg::MaxUnits; i++) begin
        burst.units[i] = (3'(i) < num_repl) ? u8u16_pkg::Replacement : tail_unit;
      end
      burst.count = num_repl + {2'd0, tail_vld};
    end
  end

  assign push = accept && (burst.count != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r    <= 2'd0;
      collected_r <= 2'd0;
      partial_r   <= '0;
    end else if (accept) begin
      needed_r    <= needed_nxt;
      collected_r <= collected_nxt;
      partial_r   <= partial_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    needed_r == 2'd0 |-> collected_r == 2'd0 && partial_r == '0)
    else $error("idle decoder holds stale sequence state");

  a_collect_bound: assert property (@(posedge clk) disable iff (!rst_n)
    needed_r != 2'd0 |-> collected_r < needed_r)
    else $error("collected continuation count reached the sequence length");

  a_string_flush: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> needed_r == 2'd0)
    else $error("sequence still pending after the string end");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/u8u16_serializer.sv =====
// ----------------------------------------------------------------------------
// Result burst queue and serializer
// Two-entry queue of bursts; sends the units of the head burst one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_serializer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire u8u16_pkg::burst_t burst,
  output logic                   full,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [15:0]            out_tdata,
  output logic [0:0]             out_tuser,
  output logic                   out_tlast
);

  u8u16_pkg::burst_t q_r [2];
  u8u16_pkg::burst_t head;
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] last_idx;
  logic       at_last;
  logic       pop;

  assign head       = q_r[rd_ptr_r];
  assign last_idx   = 2'(head.count - 3'd1);
  assign at_last    = (idx_r == last_idx);
  assign full       = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head.units[idx_r];
  assign out_tuser  = at_last;
  assign out_tlast  = at_last && head.str_last;
  assign pop        = out_tvalid && out_tready && at_last;

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
    idx_nxt = idx_r;
    if (out_tvalid && out_tready) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= burst;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("burst written into a full queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> head.count != 3'd0 && {1'b0, idx_r} < head.count)
    else $error("unit index outside the head burst");

  a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("unit index not rewound after a burst");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Turns a stream of UTF-8 bytes into a stream of UTF-16 code units.
// ----------------------------------------------------------------------------
// Input channel: one UTF-8 byte per transaction, in_tlast on the final byte of
// a string. Output channel: one UTF-16 code unit per transaction; out_tuser[0]
// marks the last unit caused by one input byte, out_tlast the last unit of a
// string. Bad or truncated sequences come out as '?' units.
// Each accepted byte is decoded in the cycle of its transaction; its units
// (zero to four) go as one burst into a two-entry queue, and the head burst
// feeds the output from its register. While out_tready is high the output
// sends one unit per cycle, so throughput is one byte per cycle while bytes
// give at most one unit each; a byte that gives k units takes k transfers.
// in_tready depends only on queue occupancy: it falls when two bursts wait.
// A stalled receiver holds the current unit stable and fills the queue, after
// which input stalls too. Reset clears the pending sequence and empties the
// queue; no input is lost or repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] code_unit
  output logic [0:0]       out_tuser,  // [0] run_last
  output logic             out_tlast
);

  u8u16_pkg::burst_t burst;
  logic              push;
  logic              full;
  logic              accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  u8u16_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .burst   (burst),
    .push    (push)
  );

  u8u16_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .burst      (burst),
    .full       (full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds byte streams into the transcoder and checks every code unit that
// comes out against a cycle-free decoder kept alongside it. A directed table
// covers the extremes and the malformed-input cases; mostly well-formed random
// characters with some noise follow. Both sides idle at random but for the end.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 73;
  localparam logic TYPED = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam logic [15:0] QMark = u8u16_pkg::Replacement;

  // One row of the directed table. Rows marked PRED take their expectation
  // from the decoder below; TYPED rows carry it in u0 to u3.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        fixed_exp;
    logic [2:0]  n_units;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] u2;
    logic [15:0] u3;
  } byte_row_t;

  typedef struct {
    logic [15:0] unit;
    logic        run_last;
    logic        str_end;
  } unit_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] byte_in
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] code_unit
  logic [0:0]  out_tuser;          // [0] run_last
  logic        out_tlast;

  utf8_to_utf16_transcoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int send_idle_pct = 10;
  int recv_idle_pct = 58;
  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int strings_closed = 0;
  int units_seen = 0;
  int repl_seen = 0;
  int surr_seen = 0;

  // Decoder state and the units of the byte being decoded.
  logic [1:0]  need_conts = 2'd0;
  logic [1:0]  got_conts = 2'd0;
  logic [20:0] code_acc = 21'd0;
  logic [15:0] burst[$];
  unit_exp_t   expected_units[$];

  byte_row_t   dir_rows[25];

  function automatic u8u16_pkg::byte_cls_t classify(input logic [7:0] b);
    casez (b)
      8'b0???????: return u8u16_pkg::CLS_ASCII;
      8'b10??????: return u8u16_pkg::CLS_CONT;
      8'b110?????: return u8u16_pkg::CLS_LEAD2;
      8'b1110????: return u8u16_pkg::CLS_LEAD3;
      8'b11110???: return u8u16_pkg::CLS_LEAD4;
      default:     return u8u16_pkg::CLS_BAD;
    endcase
  endfunction

  // A pending sequence is given up: one '?' for the lead and one per
  // continuation byte already taken.
  task automatic flush_partial();
    burst.push_back(u8u16_pkg::Replacement);
    for (int i = 0; i < got_conts; i++) burst.push_back(u8u16_pkg::Replacement);
    need_conts = 2'd0;
    got_conts = 2'd0;
    code_acc = 21'd0;
  endtask

  task automatic take_fresh(input logic [7:0] b, input logic last);
    case (classify(b))
      u8u16_pkg::CLS_ASCII: burst.push_back({8'h00, b});
      u8u16_pkg::CLS_LEAD2: begin
        need_conts = 2'd1;
        got_conts = 2'd0;
        code_acc = {16'd0, b[4:0]};
        if (last) flush_partial();
      end
      u8u16_pkg::CLS_LEAD3: begin
        need_conts = 2'd2;
        got_conts = 2'd0;
        code_acc = {17'd0, b[3:0]};
        if (last) flush_partial();
      end
      u8u16_pkg::CLS_LEAD4: begin
        need_conts = 2'd3;
        got_conts = 2'd0;
        code_acc = {18'd0, b[2:0]};
        if (last) flush_partial();
      end
      default: burst.push_back(u8u16_pkg::Replacement);
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [20:0] sup;
    burst.delete();
    if (need_conts != 2'd0) begin
      if (classify(b) == u8u16_pkg::CLS_CONT) begin
        code_acc = {code_acc[14:0], b[5:0]};
        got_conts = got_conts + 2'd1;
        if (got_conts >= need_conts) begin
          if (code_acc < u8u16_pkg::SuppBase) begin
            burst.push_back(code_acc[15:0]);
          end else begin
            // No range check: code points past 0x10FFFF still split.
            sup = code_acc - u8u16_pkg::SuppBase;
            burst.push_back(u8u16_pkg::HighSurrBase + {5'd0, sup[20:10]});
            burst.push_back(u8u16_pkg::LowSurrBase + {6'd0, sup[9:0]});
          end
          need_conts = 2'd0;
          got_conts = 2'd0;
          code_acc = 21'd0;
        end else if (last) begin
          flush_partial();
        end
      end else begin
        // The byte that broke the sequence is decoded again on its own.
        flush_partial();
        take_fresh(b, last);
      end
    end else begin
      take_fresh(b, last);
    end
  endtask

  // Drives one byte, waits for its transaction and records what it must give.
  task automatic send_byte(input byte_row_t r);
    logic [63:0] typed_units;
    unit_exp_t e;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r.data;
    in_tlast <= r.last;
    do @(posedge clk); while (!in_tready);
    decode_byte(r.data, r.last);
    if (r.fixed_exp) begin
      typed_units = {r.u3, r.u2, r.u1, r.u0};
      burst.delete();
      for (int i = 0; i < r.n_units; i++) burst.push_back(typed_units[i*16 +: 16]);
    end
    for (int i = 0; i < burst.size(); i++) begin
      e.unit = burst[i];
      e.run_last = (i == burst.size() - 1);
      e.str_end = (i == burst.size() - 1) && r.last;
      expected_units.push_back(e);
    end
    bytes_sent++;
    if (r.last) strings_closed++;
  endtask

  // Mostly whole characters with random payload bits; the rest are cut-off
  // sequences, stray continuation bytes, invalid leads and plain noise.
  task automatic send_random_seq();
    int kind;
    int len;
    int conts;
    logic close;
    logic [7:0] seq[$];
    byte_row_t r;
    kind = $urandom_range(0, 19);
    close = 1'b0;
    if (kind < 16) begin
      len = (kind < 14) ? $urandom_range(1, 4) : $urandom_range(2, 4);
      case (len)
        1: seq.push_back({1'b0, 7'($urandom)});
        2: seq.push_back({3'b110, 5'($urandom)});
        3: seq.push_back({4'b1110, 4'($urandom)});
        default: seq.push_back({5'b11110, 3'($urandom)});
      endcase
      conts = (kind < 14) ? len - 1 : $urandom_range(0, len - 2);
      for (int i = 0; i < conts; i++) seq.push_back({2'b10, 6'($urandom)});
      close = (kind < 14) ? ($urandom_range(5) == 0) : ($urandom_range(1) == 0);
    end else if (kind < 18) begin
      seq.push_back(8'($urandom));
      close = ($urandom_range(3) == 0);
    end else begin
      seq.push_back(8'($urandom_range(8'h80, 8'hFF)));
      close = ($urandom_range(3) == 0);
    end
    for (int i = 0; i < seq.size(); i++) begin
      r = '0;
      r.data = seq[i];
      r.last = close && (i == seq.size() - 1);
      r.fixed_exp = PRED;
      send_byte(r);
    end
  endtask

  // Holds the input off until every predicted unit has come out.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_units
    unit_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_units.size() == 0) begin
        $error("unexpected code unit %h", out_tdata);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (out_tdata !== want.unit) begin
          $error("code_unit: expected %h, got %h", want.unit, out_tdata);
          errors++;
        end
        if (out_tuser[0] !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_tuser[0]);
          errors++;
        end
        if (out_tlast !== want.str_end) begin
          $error("string_end: expected %b, got %b", want.str_end, out_tlast);
          errors++;
        end
        units_seen++;
        if (want.unit == u8u16_pkg::Replacement) repl_seen++;
        if (want.unit[15:11] == 5'b11011) surr_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      '{8'h00, 1'b0, TYPED, 3'd1, 16'h0000, 16'h0, 16'h0, 16'h0},
      '{8'h7F, 1'b1, TYPED, 3'd1, 16'h007F, 16'h0, 16'h0, 16'h0},
      // Stray continuation byte, then an invalid lead.
      '{8'h80, 1'b0, TYPED, 3'd1, QMark, 16'h0, 16'h0, 16'h0},
      '{8'hFF, 1'b0, TYPED, 3'd1, QMark, 16'h0, 16'h0, 16'h0},
      '{8'hC3, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hA9, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hE2, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h82, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hAC, 1'b1, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hF0, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h9F, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h98, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h80, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      // Largest 4-byte value, well past the Unicode range.
      '{8'hF7, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hBF, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hBF, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hBF, 1'b0, TYPED, 3'd2, 16'hDFBF, 16'hDFFF, 16'h0, 16'h0},
      // A lead that ends its string breaks a 4-byte sequence: four units.
      '{8'hF0, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h90, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h80, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hC2, 1'b1, TYPED, 3'd4, QMark, QMark, QMark, QMark},
      '{8'hC2, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'hFE, 1'b0, TYPED, 3'd2, QMark, QMark, 16'h0, 16'h0},
      // String ends in the middle of a 3-byte sequence.
      '{8'hE2, 1'b0, PRED, 3'd0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{8'h82, 1'b1, TYPED, 3'd2, QMark, QMark, 16'h0, 16'h0}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 10; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 10; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      bytes_sent = (ph == 0) ? 0 : bytes_sent;
      while (bytes_sent < PhaseBytes * (ph + 1)) send_random_seq();
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_units.size() != 0) begin
      $error("%0d code units never came out", expected_units.size());
      errors++;
    end
    $display("Sent %0d random bytes after the directed table, %0d string ends in all.",
             bytes_sent, strings_closed);
    $display("Checked %0d code units: %0d replacements, %0d surrogate halves.",
             units_seen, repl_seen, surr_seen);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
